>>> hdl/upwind_fifth_order_interp_assert.svh
// ---------------------------------------------------------------------------
// upwind interpolator assertion macros
// shared property forms for the concurrent checks of the block
// ---------------------------------------------------------------------------
`ifndef UPWIND_FIFTH_ORDER_INTERP_ASSERT_SVH
`define UPWIND_FIFTH_ORDER_INTERP_ASSERT_SVH

// same-cycle implication
`define UWI_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UWI_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/uwi_pkg.sv
// ---------------------------------------------------------------------------
// upwind interpolator package
// widths, register codes, stencil weights and divide-by-60 constants
// ---------------------------------------------------------------------------
package uwi_pkg;

   localparam int NUM_COMPONENTS_DEFAULT = 4;
   localparam int MAX_CELLS = 1024;

   localparam int SAMPLE_W = 32;
   localparam int CPL_W = 11;
   localparam int GHOST_W = 4;
   localparam int POS_W = 12;
   localparam int HIST_CELLS = 4;
   localparam int TAPS = HIST_CELLS + 1;
   localparam int WEIGHT_W = 8;
   localparam int SUM_W = 40;

   localparam logic [GHOST_W-1:0] GHOST_MIN = GHOST_W'(3);
   localparam logic [GHOST_W-1:0] GHOST_MAX = GHOST_W'(8);

   // register map
   localparam int CSR_W = 32;
   localparam int ADDR_W = 4;
   localparam int REG_IDX_W = 2;
   localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_CELLS = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_GHOSTS = 2'd2;

   localparam logic DIRECTION_RESET = 1'b0;
   localparam logic [CPL_W-1:0] CELLS_RESET = CPL_W'(64);
   localparam logic [GHOST_W-1:0] GHOSTS_RESET = GHOST_W'(3);

   // left-biased weights, oldest first, over 60
   localparam logic signed [WEIGHT_W-1:0] WEIGHTS [TAPS] =
      '{8'sd2, -8'sd13, 8'sd47, 8'sd27, -8'sd3};

   // rounding and divide by 60 = (>> 2) then divide by 15
   localparam int ROUND_BIAS = 30;
   localparam int DIV_BASE = 15;
   localparam int T_W = 35;
   localparam int LO_W = 17;
   localparam int HI_W = T_W - LO_W;
   localparam int QH_W = HI_W - 3;
   localparam int RH_W = 4;
   localparam int REM_W = RH_W + LO_W;
   localparam int Q_W = QH_W + LO_W;
   localparam int HI_SHIFT = HI_W + 4;
   localparam int REM_SHIFT = REM_W + 4;
   localparam int RHI_W = 19;
   localparam int RREM_W = 22;
   localparam logic [RHI_W-1:0] RECIP_HI =
      RHI_W'((2 ** HI_SHIFT + DIV_BASE - 1) / DIV_BASE);
   localparam logic [RREM_W-1:0] RECIP_REM =
      RREM_W'((2 ** REM_SHIFT + DIV_BASE - 1) / DIV_BASE);
   // anything at or above this saturates either way
   localparam logic [T_W-1:0] T_MAX = T_W'(64'd15 * 64'd2147483649);
   localparam logic [REM_W-1:0] REM_LIMIT = REM_W'(DIV_BASE * (2 ** LO_W));

   localparam logic [Q_W-1:0] SAT_NEG_MAG = 32'h8000_0000;
   localparam logic [Q_W-1:0] SAT_POS_MAG = 32'h7FFF_FFFF;

   typedef struct packed {
      logic valid;
      logic line_end;
   } uwi_ctrl_type;

endpackage

>>> hdl/uwi_cell.sv
// ---------------------------------------------------------------------------
// upwind interpolator history cell
// holds one cell's worth of samples, all components, and passes the oldest on
// ---------------------------------------------------------------------------
module uwi_cell #(
   parameter int DEPTH = uwi_pkg::NUM_COMPONENTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift_en,
   input  logic signed [uwi_pkg::SAMPLE_W-1:0]  shift_in,
   output logic signed [uwi_pkg::SAMPLE_W-1:0]  shift_out
);

   logic signed [uwi_pkg::SAMPLE_W-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            line_ff[i] <= '0;
         end
      end else if (shift_en) begin
         line_ff[0] <= shift_in;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign shift_out = line_ff[DEPTH-1];

endmodule

>>> hdl/uwi_round.sv
// ---------------------------------------------------------------------------
// upwind interpolator rounding divider
// divides the stencil sum by 60, rounds to nearest and saturates to 32 bits
// ---------------------------------------------------------------------------
`include "upwind_fifth_order_interp_assert.svh"

module uwi_round (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  uwi_pkg::uwi_ctrl_type                in_ctrl,
   input  logic signed [uwi_pkg::SUM_W-1:0]     in_sum,
   output uwi_pkg::uwi_ctrl_type                out_ctrl,
   output logic signed [uwi_pkg::SAMPLE_W-1:0]  out_value
);

   // stage 1: magnitude plus rounding bias, divided by 4, clamped
   logic                          neg_in;
   logic [uwi_pkg::SUM_W-1:0]     sum_u;
   logic [uwi_pkg::SUM_W-1:0]     biased;
   logic [uwi_pkg::SUM_W-3:0]     t_full;
   logic [uwi_pkg::T_W-1:0]       t_in;
   uwi_pkg::uwi_ctrl_type         r1_ctrl_ff;
   logic                          r1_neg_ff;
   logic [uwi_pkg::T_W-1:0]       r1_t_ff;

   assign neg_in = in_sum[uwi_pkg::SUM_W-1];
   assign sum_u  = in_sum;
   // for a negative sum, ~s is |s| - 1, so one more unit of bias
   assign biased = neg_in ? (~sum_u + uwi_pkg::SUM_W'(uwi_pkg::ROUND_BIAS + 1))
                          : (sum_u + uwi_pkg::SUM_W'(uwi_pkg::ROUND_BIAS));
   assign t_full = biased[uwi_pkg::SUM_W-1:2];
   assign t_in   = (t_full > (uwi_pkg::SUM_W-2)'(uwi_pkg::T_MAX)) ? uwi_pkg::T_MAX
                                                                 : t_full[uwi_pkg::T_W-1:0];

   // stage 2: high digit divided by 15 through a reciprocal
   logic [uwi_pkg::HI_W-1:0]              hi;
   logic [uwi_pkg::HI_W+uwi_pkg::RHI_W-1:0] prod_hi;
   uwi_pkg::uwi_ctrl_type                 r2_ctrl_ff;
   logic                                  r2_neg_ff;
   logic [uwi_pkg::QH_W-1:0]              r2_qh_ff;
   logic [uwi_pkg::HI_W-1:0]              r2_hi_ff;
   logic [uwi_pkg::LO_W-1:0]              r2_lo_ff;

   assign hi      = r1_t_ff[uwi_pkg::T_W-1:uwi_pkg::LO_W];
   assign prod_hi = (uwi_pkg::HI_W+uwi_pkg::RHI_W)'(hi)
                  * (uwi_pkg::HI_W+uwi_pkg::RHI_W)'(uwi_pkg::RECIP_HI);

   // stage 3: remainder of the high digit joined to the low part
   logic [uwi_pkg::HI_W-1:0]   rh_full;
   uwi_pkg::uwi_ctrl_type      r3_ctrl_ff;
   logic                       r3_neg_ff;
   logic [uwi_pkg::QH_W-1:0]   r3_qh_ff;
   logic [uwi_pkg::REM_W-1:0]  r3_rem_ff;

   assign rh_full = r2_hi_ff - uwi_pkg::HI_W'(r2_qh_ff) * uwi_pkg::HI_W'(uwi_pkg::DIV_BASE);

   // stage 4: low quotient digit
   logic [uwi_pkg::REM_W+uwi_pkg::RREM_W-1:0] prod_rem;
   uwi_pkg::uwi_ctrl_type      r4_ctrl_ff;
   logic                       r4_neg_ff;
   logic [uwi_pkg::QH_W-1:0]   r4_qh_ff;
   logic [uwi_pkg::LO_W-1:0]   r4_q2_ff;

   assign prod_rem = (uwi_pkg::REM_W+uwi_pkg::RREM_W)'(r3_rem_ff)
                   * (uwi_pkg::REM_W+uwi_pkg::RREM_W)'(uwi_pkg::RECIP_REM);

   // stage 5: sign and saturation into the output register
   logic [uwi_pkg::Q_W-1:0]       q;
   logic [uwi_pkg::SAMPLE_W-1:0]  value_in;
   uwi_pkg::uwi_ctrl_type         out_ctrl_ff;
   logic signed [uwi_pkg::SAMPLE_W-1:0] out_value_ff;

   assign q = {r4_qh_ff, r4_q2_ff};

   always_comb begin
      if (r4_neg_ff) begin
         value_in = (q > uwi_pkg::SAT_NEG_MAG) ? uwi_pkg::SAT_NEG_MAG : (~q + 1'b1);
      end else begin
         value_in = (q > uwi_pkg::SAT_POS_MAG) ? uwi_pkg::SAT_POS_MAG : q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_ctrl_ff  <= '0;
         r2_ctrl_ff  <= '0;
         r3_ctrl_ff  <= '0;
         r4_ctrl_ff  <= '0;
         out_ctrl_ff <= '0;
      end else if (advance) begin
         r1_ctrl_ff  <= in_ctrl;
         r2_ctrl_ff  <= r1_ctrl_ff;
         r3_ctrl_ff  <= r2_ctrl_ff;
         r4_ctrl_ff  <= r3_ctrl_ff;
         out_ctrl_ff <= r4_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r1_neg_ff    <= neg_in;
         r1_t_ff      <= t_in;
         r2_neg_ff    <= r1_neg_ff;
         r2_qh_ff     <= prod_hi[uwi_pkg::HI_SHIFT +: uwi_pkg::QH_W];
         r2_hi_ff     <= hi;
         r2_lo_ff     <= r1_t_ff[uwi_pkg::LO_W-1:0];
         r3_neg_ff    <= r2_neg_ff;
         r3_qh_ff     <= r2_qh_ff;
         r3_rem_ff    <= {rh_full[uwi_pkg::RH_W-1:0], r2_lo_ff};
         r4_neg_ff    <= r3_neg_ff;
         r4_qh_ff     <= r3_qh_ff;
         r4_q2_ff     <= prod_rem[uwi_pkg::REM_SHIFT +: uwi_pkg::LO_W];
         out_value_ff <= value_in;
      end
   end

   assign out_ctrl  = out_ctrl_ff;
   assign out_value = out_value_ff;

   // a wrong high quotient digit leaves a remainder of 15 or more
   `UWI_ASSERT_NOW(a_rem_bound, clock, reset, r3_ctrl_ff.valid,
      r3_rem_ff < uwi_pkg::REM_LIMIT, "high quotient digit off by one")
   `UWI_ASSERT_NEXT(a_valid_moves, clock, reset, advance,
      r2_ctrl_ff.valid == $past(r1_ctrl_ff.valid), "valid lost between stages")

endmodule

>>> hdl/upwind_fifth_order_interp.sv
// ---------------------------------------------------------------------------
// fifth-order upwind interface interpolator
// streams the samples of one grid line and returns its interface values
// ---------------------------------------------------------------------------
// Samples of one grid line enter one per transfer, cell by cell, with the
// components of a cell interleaved and the ghost cells included. Each
// accepted sample either yields one interface value or none: the first
// ghost_cells+1 cells of a line (one more when right-biased) and the last
// ghost_cells-2 cells (one fewer when right-biased) give nothing. One sample
// is taken every clock cycle while the result side keeps up; the figure is
// set by the stencil pipeline, which moves all its stages together, so a
// stalled result stops intake only once the output register is full and
// not taken. A result passes through operand capture, two adder stages, four
// divide-by-60 stages and saturation into the rsp_ register. History lives in
// a chain of four cells, each holding one cell's worth of components; it
// resets to zero, so there is no clearing pass. The user writes registers
// through the csr_ port only while the block is idle; it is not enforced.
// ---------------------------------------------------------------------------
`include "upwind_fifth_order_interp_assert.svh"

module upwind_fifth_order_interp #(
   parameter int NUM_COMPONENTS = uwi_pkg::NUM_COMPONENTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [uwi_pkg::SAMPLE_W-1:0]  req_sample,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [uwi_pkg::SAMPLE_W-1:0]  rsp_value,
   output logic                                 rsp_line_end,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [uwi_pkg::ADDR_W-1:0]           csr_paddr,
   input  logic [uwi_pkg::CSR_W-1:0]            csr_pwdata,
   output logic [uwi_pkg::CSR_W-1:0]            csr_prdata,
   output logic                                 csr_pready
);

   localparam int COMP_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
   localparam logic [COMP_W-1:0] COMP_LAST = COMP_W'(NUM_COMPONENTS - 1);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic                          direction_ff;
   logic [uwi_pkg::CPL_W-1:0]     cells_ff;
   logic [uwi_pkg::GHOST_W-1:0]   ghosts_ff;
   logic                          csr_write;
   logic [uwi_pkg::REG_IDX_W-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   // byte address 4*i, low two bits ignored
   assign reg_idx    = csr_paddr[uwi_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= uwi_pkg::DIRECTION_RESET;
         cells_ff     <= uwi_pkg::CELLS_RESET;
         ghosts_ff    <= uwi_pkg::GHOSTS_RESET;
      end else if (csr_write) begin
         unique case (reg_idx)
            uwi_pkg::REG_DIRECTION: begin
               direction_ff <= csr_pwdata[0];
            end
            uwi_pkg::REG_CELLS: begin
               cells_ff <= csr_pwdata[uwi_pkg::CPL_W-1:0];
            end
            uwi_pkg::REG_GHOSTS: begin
               ghosts_ff <= csr_pwdata[uwi_pkg::GHOST_W-1:0];
            end
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         uwi_pkg::REG_DIRECTION: csr_prdata = uwi_pkg::CSR_W'(direction_ff);
         uwi_pkg::REG_CELLS:     csr_prdata = uwi_pkg::CSR_W'(cells_ff);
         uwi_pkg::REG_GHOSTS:    csr_prdata = uwi_pkg::CSR_W'(ghosts_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // effective line geometry
   // ------------------------------------------------------------------
   logic [uwi_pkg::POS_W-1:0]   eff_cells;
   logic [uwi_pkg::GHOST_W-1:0] eff_ghosts;
   logic [uwi_pkg::POS_W-1:0]   line_len;
   logic [uwi_pkg::POS_W-1:0]   first_cell;
   logic [uwi_pkg::POS_W-1:0]   last_cell;

   always_comb begin
      if (cells_ff == '0) begin
         eff_cells = uwi_pkg::POS_W'(1);
      end else if (32'(cells_ff) > uwi_pkg::MAX_CELLS) begin
         eff_cells = uwi_pkg::POS_W'(uwi_pkg::MAX_CELLS);
      end else begin
         eff_cells = uwi_pkg::POS_W'(cells_ff);
      end
      if (ghosts_ff < uwi_pkg::GHOST_MIN) begin
         eff_ghosts = uwi_pkg::GHOST_MIN;
      end else if (ghosts_ff > uwi_pkg::GHOST_MAX) begin
         eff_ghosts = uwi_pkg::GHOST_MAX;
      end else begin
         eff_ghosts = ghosts_ff;
      end
   end

   assign line_len   = eff_cells + uwi_pkg::POS_W'({eff_ghosts, 1'b0});
   // right-biased window sits one cell later
   assign first_cell = uwi_pkg::POS_W'(eff_ghosts) + uwi_pkg::POS_W'(1)
                     + uwi_pkg::POS_W'(direction_ff);
   assign last_cell  = first_cell + eff_cells;

   // ------------------------------------------------------------------
   // position counters
   // ------------------------------------------------------------------
   logic                        advance;
   logic                        accept;
   logic [uwi_pkg::POS_W-1:0]   cell_ff;
   logic [uwi_pkg::POS_W-1:0]   cell_in;
   logic [COMP_W-1:0]           comp_ff;
   logic [COMP_W-1:0]           comp_in;
   logic [COMP_W-1:0]           comp_eff;
   logic                        comp_wrap;
   logic                        in_window;
   logic                        line_end_in;

   // pipeline moves whenever the output register is free or being drained
   assign advance   = ~rsp_valid | rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid & advance;

   assign comp_eff    = (32'(comp_ff) >= NUM_COMPONENTS) ? '0 : comp_ff;
   assign comp_wrap   = (comp_eff == COMP_LAST);
   assign in_window   = (cell_ff >= first_cell) && (cell_ff <= last_cell);
   assign line_end_in = (cell_ff == last_cell) && comp_wrap;

   always_comb begin
      comp_in = comp_eff + COMP_W'(1);
      cell_in = cell_ff;
      if (comp_wrap) begin
         comp_in = '0;
         if ((uwi_pkg::POS_W+1)'(cell_ff) + 1'b1 >= (uwi_pkg::POS_W+1)'(line_len)) begin
            cell_in = '0;
         end else begin
            cell_in = cell_ff + uwi_pkg::POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
         comp_ff <= '0;
      end else if (accept) begin
         cell_ff <= cell_in;
         comp_ff <= comp_in;
      end
   end

   // ------------------------------------------------------------------
   // history chain: chain[0] is the new sample, chain[k] is k cells back
   // ------------------------------------------------------------------
   logic signed [uwi_pkg::SAMPLE_W-1:0] chain [uwi_pkg::HIST_CELLS+1];

   assign chain[0] = req_sample;

   for (genvar i = 0; i < uwi_pkg::HIST_CELLS; i++) begin : g_hist
      uwi_cell #(
         .DEPTH (NUM_COMPONENTS)
      ) hist_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (accept),
         .shift_in  (chain[i]),
         .shift_out (chain[i+1])
      );
   end

   // ------------------------------------------------------------------
   // stage 1: operand capture, window mirrored for right bias
   // ------------------------------------------------------------------
   uwi_pkg::uwi_ctrl_type               p1_ctrl_ff;
   logic signed [uwi_pkg::SAMPLE_W-1:0] p1_tap_ff [uwi_pkg::TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ctrl_ff <= '0;
      end else if (advance) begin
         p1_ctrl_ff.valid    <= accept & in_window;
         p1_ctrl_ff.line_end <= line_end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < uwi_pkg::TAPS; k++) begin
            // oldest first when left-biased, newest first when mirrored
            p1_tap_ff[k] <= direction_ff ? chain[k] : chain[uwi_pkg::TAPS-1-k];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 2: weighted taps in two partial sums
   // ------------------------------------------------------------------
   logic signed [uwi_pkg::SUM_W-1:0] prod [uwi_pkg::TAPS];
   uwi_pkg::uwi_ctrl_type            p2_ctrl_ff;
   logic signed [uwi_pkg::SUM_W-1:0] p2_sum_a_ff;
   logic signed [uwi_pkg::SUM_W-1:0] p2_sum_b_ff;

   always_comb begin
      for (int k = 0; k < uwi_pkg::TAPS; k++) begin
         prod[k] = uwi_pkg::SUM_W'(p1_tap_ff[k]) * uwi_pkg::SUM_W'(uwi_pkg::WEIGHTS[k]);
      end
   end

   // ------------------------------------------------------------------
   // stage 3: full stencil sum
   // ------------------------------------------------------------------
   uwi_pkg::uwi_ctrl_type            p3_ctrl_ff;
   logic signed [uwi_pkg::SUM_W-1:0] p3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ctrl_ff <= '0;
         p3_ctrl_ff <= '0;
      end else if (advance) begin
         p2_ctrl_ff <= p1_ctrl_ff;
         p3_ctrl_ff <= p2_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_sum_a_ff <= prod[0] + prod[1] + prod[2];
         p2_sum_b_ff <= prod[3] + prod[4];
         p3_sum_ff   <= p2_sum_a_ff + p2_sum_b_ff;
      end
   end

   // ------------------------------------------------------------------
   // stages 4 to 8: divide by 60, round, saturate, output register
   // ------------------------------------------------------------------
   uwi_pkg::uwi_ctrl_type rsp_ctrl;

   uwi_round round_unit (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctrl   (p3_ctrl_ff),
      .in_sum    (p3_sum_ff),
      .out_ctrl  (rsp_ctrl),
      .out_value (rsp_value)
   );

   assign rsp_valid    = rsp_ctrl.valid;
   assign rsp_line_end = rsp_ctrl.line_end;

   // position bookkeeping
   `UWI_ASSERT_NEXT(a_comp_wrap, clock, reset, accept && comp_wrap,
      comp_ff == '0, "component position failed to wrap")
   `UWI_ASSERT_NEXT(a_cell_hold, clock, reset, accept && !comp_wrap,
      cell_ff == $past(cell_ff), "cell position moved inside a cell")
   `UWI_ASSERT_NEXT(a_idle_hold, clock, reset, !accept,
      $stable(comp_ff) && $stable(cell_ff), "position moved without a transfer")

endmodule

>>> sim/upwind_fifth_order_interp_tb.sv
// ---------------------------------------------------------------------------
// upwind interpolator testbench
// streams grid lines of samples through the interpolator under random flow
// control, predicts every interface value from a behavioural stencil and
// checks value and line end of each result in order, across several
// register settings written and read back through the csr_ port
// ---------------------------------------------------------------------------
module upwind_fifth_order_interp_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NC = uwi_pkg::NUM_COMPONENTS_DEFAULT;
   localparam int DRAIN_CYCLES = 16;    // margin beyond the pipeline depth

   // register index with nothing behind it
   localparam logic [uwi_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

   localparam logic signed [uwi_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [uwi_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   // left-biased stencil, oldest cell first; the right-biased one is its mirror
   localparam int LEFT_WEIGHTS [uwi_pkg::HIST_CELLS+1] = '{2, -13, 47, 27, -3};

   // opening line: one interior cell, three ghosts, left-biased
   // component 0 drives positive saturation, component 1 negative,
   // component 2 lands on rounding ties, component 3 toggles around zero
   localparam logic signed [uwi_pkg::SAMPLE_W-1:0] OPENING_LINE [NC][7] = '{
      '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 32'sd0},
      '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 32'sd0},
      '{32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd10, -32'sd80, 32'sd0},
      '{-32'sd1, 32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1, -32'sd1}
   };

   typedef struct {
      logic signed [uwi_pkg::SAMPLE_W-1:0] value;
      logic                                line_end;
   } iface_value_type;

   // -----------------------------------------------------------------------
   // stencil predictor and store of pending interface values
   // -----------------------------------------------------------------------
   class interp_scoreboard;
      logic                                dir_reg;
      logic [uwi_pkg::CPL_W-1:0]           cells_reg;
      logic [uwi_pkg::GHOST_W-1:0]         ghost_reg;
      logic signed [uwi_pkg::SAMPLE_W-1:0] history [uwi_pkg::HIST_CELLS][NC];
      int                                  cell_pos;
      int                                  comp_pos;
      iface_value_type                     pending [$];
      int                                  accepted;
      int                                  checked;
      int                                  line_ends;
      int                                  errors;

      function new();
         dir_reg   = uwi_pkg::DIRECTION_RESET;
         cells_reg = uwi_pkg::CELLS_RESET;
         ghost_reg = uwi_pkg::GHOSTS_RESET;
         foreach (history[k, v]) history[k][v] = '0;
         cell_pos  = 0;
         comp_pos  = 0;
         accepted  = 0;
         checked   = 0;
         line_ends = 0;
         errors    = 0;
      endfunction

      function void set_register(logic [uwi_pkg::REG_IDX_W-1:0] idx,
                                 logic [uwi_pkg::CSR_W-1:0] data);
         case (idx)
            uwi_pkg::REG_DIRECTION: dir_reg   = data[0];
            uwi_pkg::REG_CELLS:     cells_reg = data[uwi_pkg::CPL_W-1:0];
            uwi_pkg::REG_GHOSTS:    ghost_reg = data[uwi_pkg::GHOST_W-1:0];
            default: ;
         endcase
      endfunction

      function void check_register(logic [uwi_pkg::REG_IDX_W-1:0] idx,
                                   logic [uwi_pkg::CSR_W-1:0] got);
         logic [uwi_pkg::CSR_W-1:0] want;
         case (idx)
            uwi_pkg::REG_DIRECTION: want = uwi_pkg::CSR_W'(dir_reg);
            uwi_pkg::REG_CELLS:     want = uwi_pkg::CSR_W'(cells_reg);
            uwi_pkg::REG_GHOSTS:    want = uwi_pkg::CSR_W'(ghost_reg);
            default:                return;
         endcase
         if (got !== want) begin
            errors++;
            $display("%0t: register %0d read back mismatch: expected %0h, got %0h",
                     $time, idx, want, got);
         end
      endfunction

      // one accepted sample: maybe one interface value, then history and position move on
      function void note_sample(logic signed [uwi_pkg::SAMPLE_W-1:0] s);
         int              n;
         int              g;
         int              len;
         int              first;
         int              last;
         int              w;
         longint          acc;
         longint          mag;
         longint          q;
         iface_value_type r;

         accepted++;
         n = cells_reg;
         if (n < 1) n = 1;
         if (n > uwi_pkg::MAX_CELLS) n = uwi_pkg::MAX_CELLS;
         g = ghost_reg;
         if (g < 3) g = 3;
         if (g > 8) g = 8;
         len   = n + 2 * g;
         first = g + 1 + int'(dir_reg);
         last  = n + g + 1 + int'(dir_reg);

         if (cell_pos >= first && cell_pos <= last) begin
            acc = 0;
            for (int k = 0; k <= uwi_pkg::HIST_CELLS; k++) begin
               w = dir_reg ? LEFT_WEIGHTS[uwi_pkg::HIST_CELLS-k] : LEFT_WEIGHTS[k];
               if (k < uwi_pkg::HIST_CELLS) acc += longint'(w) * longint'(history[k][comp_pos]);
               else acc += longint'(w) * longint'(s);
            end
            // divide by 60, nearest with ties away from zero, then saturate
            mag = (acc < 0) ? -acc : acc;
            q = (mag + 30) / 60;
            if (acc < 0) begin
               if (q > 64'd2147483648) q = 64'd2147483648;
               r.value = uwi_pkg::SAMPLE_W'(-q);
            end else begin
               if (q > 64'd2147483647) q = 64'd2147483647;
               r.value = uwi_pkg::SAMPLE_W'(q);
            end
            r.line_end = (cell_pos == last) && (comp_pos == NC - 1);
            pending.push_back(r);
         end

         for (int k = 0; k < uwi_pkg::HIST_CELLS - 1; k++) begin
            history[k][comp_pos] = history[k+1][comp_pos];
         end
         history[uwi_pkg::HIST_CELLS-1][comp_pos] = s;

         if (comp_pos + 1 >= NC) begin
            comp_pos = 0;
            cell_pos = (cell_pos + 1 >= len) ? 0 : cell_pos + 1;
         end else begin
            comp_pos++;
         end
      endfunction

      function void check_result(logic signed [uwi_pkg::SAMPLE_W-1:0] value, logic line_end);
         iface_value_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected interface value %0d (line end %0b)", $time, value, line_end);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (line_end === 1'b1) line_ends++;
         if (value !== want.value) begin
            errors++;
            $display("%0t: interface value mismatch: expected %0d, got %0d",
                     $time, want.value, value);
         end
         if (line_end !== want.line_end) begin
            errors++;
            $display("%0t: line end mismatch: expected %0b, got %0b",
                     $time, want.line_end, line_end);
         end
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // block and its ports, all inputs known from time zero
   // -----------------------------------------------------------------------
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [uwi_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [uwi_pkg::SAMPLE_W-1:0] rsp_value;
   logic                                rsp_line_end;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [uwi_pkg::ADDR_W-1:0]          csr_paddr = '0;
   logic [uwi_pkg::CSR_W-1:0]           csr_pwdata = '0;
   logic [uwi_pkg::CSR_W-1:0]           csr_prdata;
   logic                                csr_pready;

   interp_scoreboard sb;
   int tx_idle_pct = 0;    // chance of an idle cycle before each sample
   int rx_stall_pct = 0;   // chance of holding rsp_ready low in a cycle
   int settings_used = 0;

   upwind_fifth_order_interp #(.NUM_COMPONENTS(NC)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_value    (rsp_value),
      .rsp_line_end (rsp_line_end),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always #10 clock = ~clock;

   // result side back-pressure, drawn fresh every cycle
   always @(posedge clock) begin
      if (rx_stall_pct == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // both channels watched in one place: a sample is noted before any result
   // of the same edge is checked, so ordering never hangs on the scheduler
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_sample(req_sample);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_value, rsp_line_end);
      end
   end

   // -----------------------------------------------------------------------
   // drivers
   // -----------------------------------------------------------------------

   // idle cycles drawn one at a time, then hold one sample until its transfer
   task automatic send_sample(input logic signed [uwi_pkg::SAMPLE_W-1:0] s);
      while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // stop sending and let every pending interface value come out,
   // then a few quiet cycles for samples that produce nothing
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write followed by a read back
   task automatic csr_write(input logic [uwi_pkg::REG_IDX_W-1:0] idx,
                            input logic [uwi_pkg::CSR_W-1:0] data);
      for (int xfer = 0; xfer < 2; xfer++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= (xfer == 0);
         csr_paddr   <= {idx, 2'b00};
         csr_pwdata  <= data;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (xfer == 0) sb.set_register(idx, data);
         else sb.check_register(idx, csr_prdata);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         @(posedge clock);
      end
   endtask

   // mostly full-range and Q16.16-sized values, with a share of extremes
   function automatic logic signed [uwi_pkg::SAMPLE_W-1:0] pick_sample();
      logic signed [uwi_pkg::SAMPLE_W-1:0] s;
      case ($urandom_range(0, 9))
         0:       s = SAMPLE_MAX;
         1:       s = SAMPLE_MIN;
         2:       s = uwi_pkg::SAMPLE_W'($urandom_range(0, 16)) - 32'd8;
         3, 4:    s = uwi_pkg::SAMPLE_W'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
         default: s = $urandom();
      endcase
      return s;
   endfunction

   // one register setting: written while idle, then a random stream that
   // stops at an arbitrary point in the line and drains once on the way
   task automatic run_phase(input logic [uwi_pkg::CSR_W-1:0] dir_word,
                            input logic [uwi_pkg::CSR_W-1:0] cells_word,
                            input logic [uwi_pkg::CSR_W-1:0] ghost_word, input int n);
      int hold_at;
      hold_at = $urandom_range(1, n - 1);
      wait_drained();
      csr_write(uwi_pkg::REG_DIRECTION, dir_word);
      csr_write(uwi_pkg::REG_CELLS, cells_word);
      csr_write(uwi_pkg::REG_GHOSTS, ghost_word);
      settings_used++;
      for (int i = 0; i < n; i++) begin
         if (i == hold_at) wait_drained();
         send_sample(pick_sample());
      end
   endtask

   // -----------------------------------------------------------------------
   // run
   // -----------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first third: sender idles now and then, receiver stalls often
      tx_idle_pct  = 14;
      rx_stall_pct = 52;

      // opening line with the smallest interior, saturation and ties
      csr_write(uwi_pkg::REG_DIRECTION, 32'd0);
      csr_write(uwi_pkg::REG_CELLS, 32'd1);
      csr_write(uwi_pkg::REG_GHOSTS, 32'd3);
      settings_used++;
      for (int c = 0; c < 7; c++) begin
         for (int v = 0; v < NC; v++) send_sample(OPENING_LINE[v][c]);
      end

      // right-biased through a wide word, widest ghost margin
      run_phase(32'hFFFF_FFFF, 32'd1, 32'd8, 200);
      // nothing answers at the spare index
      wait_drained();
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      // zero interior and too few ghosts, both clamped up; direction from bit 0 only
      run_phase(32'h0000_0002, 32'd0, 32'd2, 200);

      // second third: the other way round
      tx_idle_pct  = 52;
      rx_stall_pct = 14;
      run_phase(32'd1, 32'd5, 32'd15, 250);
      // full-size line, left mid-way so the next setting cuts it short
      run_phase(32'd0, 32'd1024, 32'd3, 500);
      run_phase(32'd1, 32'd3, 32'd3, 200);

      // last third: no idling anywhere
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      run_phase(32'd0, 32'd2047, 32'd8, 300);
      run_phase(32'd1, 32'd64, 32'd4, 250);
      run_phase(32'd0, 32'd7, 32'd5, 200);

      wait_drained();
      $display("streamed %0d samples over %0d register settings in both stencil directions",
               sb.accepted, settings_used);
      $display("checked %0d interface values, %0d of them closing a line",
               sb.checked, sb.line_ends);
      if (sb.errors == 0) begin
         $display("upwind_fifth_order_interp_tb: done, clean");
      end else begin
         $display("upwind_fifth_order_interp_tb: done, errors");
      end
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("upwind_fifth_order_interp_tb: done, errors");
      $finish;
   end

endmodule
